>>> design/assert_macros.svh
// Assertion macros for the RTL files; only the controller includes them.
// Simulation builds get concurrent assertions; synthesis builds define SYNTH
// and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge outside reset.
`define TTS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// An expression that must never be true at a clock edge outside reset.
`define TTS_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define TTS_ASSERT(lbl, clk, rst_n, prop)
`define TTS_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> design/tts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    // Default sizing of the lookup table and of the search.
    localparam int TTS_TABLE_DEPTH = 32;
    localparam int TTS_MAX_STEPS   = 16;

    // Field widths.
    localparam int TTS_CFG_W   = 6;
    localparam int TTS_INDEX_W = 5;
    localparam int TTS_VOLT_W  = 10;
    localparam int TTS_TEMP_W  = 8;
    localparam int TTS_MV_W    = 14;

    // Table size after reset.
    localparam logic [TTS_CFG_W-1:0] TTS_SIZE_RESET = 6'd32;

    // Request modes.
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [TTS_INDEX_W-1:0] entry_index;
        logic [TTS_VOLT_W-1:0]  entry_voltage;
        logic [TTS_TEMP_W-1:0]  entry_temperature;
        logic [TTS_MV_W-1:0]    sample_mv;
    } tts_request_t;

    typedef struct packed {
        logic [TTS_TEMP_W-1:0]  temperature;
        logic [TTS_INDEX_W-1:0] chosen_index;
    } tts_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // write one table entry
        logic init;     // capture the sample and start the search
        logic eval;     // judge the current pair and move or finish
        logic finish;   // pick the nearer entry and read its temperature
    } tts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stop;     // the search ends on this evaluation
    } tts_status_t;

    // Converts a voltage in 10 mV units to millivolts.
    function automatic logic [TTS_MV_W-1:0] times_ten(input logic [TTS_VOLT_W-1:0] v);
        logic [TTS_MV_W-1:0] ext;
        begin
            ext = TTS_MV_W'(v);
            return (ext << 3) + (ext << 1);
        end
    endfunction

endpackage

`default_nettype wire

>>> design/thermistor_table_search_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Handshake                     Payload
// request     start in, busy out            request (mode, entry, sample)
// result      result_valid strobe out       result (temperature, chosen_index)
// config      cfg_valid in, cfg_ready out   cfg_data (table size)
//
// A load request writes its entry at the accepting edge and leaves busy low.
// A conversion runs k search passes (1 to MAX_STEPS+1), each waiting on the
// registered voltage memory read, then reads, compares and strobes its result.
// A new request is taken in the cycle that shows the result.
// Reset clears the controller and sets the table size to 32; table entries
// stay undefined until loaded. The receiver cannot stall the result.

module thermistor_table_search_core #(
    parameter int TABLE_DEPTH = tts_pkg::TTS_TABLE_DEPTH,
    parameter int MAX_STEPS   = tts_pkg::TTS_MAX_STEPS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire tts_pkg::tts_request_t         request,
    output logic                               result_valid,
    output tts_pkg::tts_result_t               result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tts_pkg::TTS_CFG_W-1:0] cfg_data
);

    tts_pkg::tts_cmd_t    cmd;
    tts_pkg::tts_status_t status;
    logic                 cfg_we;

    // Configuration is taken only between conversions.
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    tts_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (request.mode),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    tts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_STEPS   (MAX_STEPS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .request  (request),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

endmodule

`default_nettype wire

>>> design/tts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tts_datapath #(
    parameter int TABLE_DEPTH = tts_pkg::TTS_TABLE_DEPTH,
    parameter int MAX_STEPS   = tts_pkg::TTS_MAX_STEPS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tts_pkg::TTS_CFG_W-1:0]  cfg_data,
    input  wire tts_pkg::tts_request_t          request,
    input  wire tts_pkg::tts_cmd_t              cmd,
    output tts_pkg::tts_status_t                status,
    output tts_pkg::tts_result_t                result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = AW + 1;
    localparam int CW = (SW > tts_pkg::TTS_CFG_W) ? SW : tts_pkg::TTS_CFG_W;
    localparam int PW = $clog2(MAX_STEPS + 1);
    localparam int MW = tts_pkg::TTS_MV_W;

    // Table memories.
    logic [tts_pkg::TTS_VOLT_W-1:0] volt_mem [TABLE_DEPTH];
    logic [tts_pkg::TTS_TEMP_W-1:0] temp_mem [TABLE_DEPTH];

    logic [tts_pkg::TTS_CFG_W-1:0]  table_size_reg;
    logic [SW-1:0]                  size_reg;
    logic [SW-1:0]                  eff_size;
    logic [CW-1:0]                  cfg_ext;
    logic [MW-1:0]                  sample_reg;
    logic [AW-1:0]                  pos_reg;
    logic [AW-1:0]                  pos_next;
    logic [AW-1:0]                  pos_hi;
    logic [AW-1:0]                  step_reg;
    logic [AW-1:0]                  step_next;
    logic [AW-1:0]                  step_new;
    logic [PW-1:0]                  passes_reg;
    logic [PW-1:0]                  passes_next;
    logic [tts_pkg::TTS_VOLT_W-1:0] v_lo_reg;
    logic [tts_pkg::TTS_VOLT_W-1:0] v_hi_reg;
    logic [AW-1:0]                  pick_reg;
    logic [AW-1:0]                  pick_next;
    logic [tts_pkg::TTS_TEMP_W-1:0] t_rd_reg;
    logic [MW-1:0]                  lo_mv;
    logic [MW-1:0]                  hi_mv;
    logic [MW-1:0]                  d_lo;
    logic [MW-1:0]                  d_hi;
    logic [EW-1:0]                  pos_ext;
    logic [EW-1:0]                  size_ext;
    logic                           found;
    logic                           capped;
    logic                           out_of_range;
    logic                           stop;
    logic                           load_ok;

    // Size register, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= tts_pkg::TTS_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            table_size_reg <= cfg_data;
        end
    end

    // The size in use is clamped to at least two and at most the table depth.
    always_comb
    begin
        cfg_ext = CW'(table_size_reg);
        if (cfg_ext < CW'(2))
        begin
            eff_size = SW'(2);
        end
        else if (cfg_ext > CW'(TABLE_DEPTH))
        begin
            eff_size = SW'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = SW'(cfg_ext);
        end
    end

    // Load requests beyond the table depth are dropped.
    assign load_ok = cmd.load && (32'(request.entry_index) < TABLE_DEPTH);

    // Voltage memory: one write port, two registered read ports at the
    // current position and its upper neighbor.
    assign pos_hi = pos_reg + AW'(1);

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            volt_mem[AW'(request.entry_index)] <= request.entry_voltage;
        end
        v_lo_reg <= volt_mem[pos_reg];
        v_hi_reg <= volt_mem[pos_hi];
    end

    // Judge the current pair from the registered reads.
    assign lo_mv    = tts_pkg::times_ten(v_lo_reg);
    assign hi_mv    = tts_pkg::times_ten(v_hi_reg);
    assign pos_ext  = EW'(pos_reg);
    assign size_ext = EW'(size_reg);

    always_comb
    begin
        // The entry at the table size counts as infinitely high.
        found = (lo_mv <= sample_reg)
            && ((pos_ext + EW'(1) >= size_ext) || (hi_mv > sample_reg));
        capped = (passes_reg >= PW'(MAX_STEPS));
        // The step halves until it reaches one.
        step_new = (step_reg >= AW'(2)) ? (step_reg >> 1) : step_reg;
        out_of_range = (pos_ext + EW'(step_new) >= size_ext) || (pos_reg < step_new);
        stop = found || capped || out_of_range;
    end

    assign status.stop = stop;

    // Next search position, step and pass count.
    always_comb
    begin
        pos_next    = pos_reg;
        step_next   = step_reg;
        passes_next = passes_reg;
        if (cmd.init)
        begin
            pos_next    = AW'(eff_size >> 1);
            step_next   = AW'(eff_size >> 1);
            passes_next = '0;
        end
        else if (cmd.eval)
        begin
            if (stop)
            begin
                // A final position on the last entry steps down by one.
                if (pos_ext == size_ext - EW'(1))
                begin
                    pos_next = pos_reg - AW'(1);
                end
            end
            else
            begin
                passes_next = passes_reg + PW'(1);
                step_next   = step_new;
                if (lo_mv < sample_reg)
                begin
                    pos_next = pos_reg + step_new;
                end
                else if (lo_mv > sample_reg)
                begin
                    pos_next = pos_reg - step_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            sample_reg <= request.sample_mv;
            size_reg   <= eff_size;
        end
        pos_reg    <= pos_next;
        step_reg   <= step_next;
        passes_reg <= passes_next;
    end

    // Nearer of the final pair; ties go to the lower entry.
    always_comb
    begin
        d_lo = (lo_mv > sample_reg) ? (lo_mv - sample_reg) : (sample_reg - lo_mv);
        d_hi = (hi_mv > sample_reg) ? (hi_mv - sample_reg) : (sample_reg - hi_mv);
        pick_next = (d_hi < d_lo) ? pos_hi : pos_reg;
    end

    // Temperature memory: written by loads, read once per conversion.
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            temp_mem[AW'(request.entry_index)] <= request.entry_temperature;
        end
        if (cmd.finish)
        begin
            t_rd_reg <= temp_mem[pick_next];
            pick_reg <= pick_next;
        end
    end

    assign result.temperature  = t_rd_reg;
    assign result.chosen_index = tts_pkg::TTS_INDEX_W'(pick_reg);

endmodule

`default_nettype wire

>>> design/tts_controller.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tts_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 mode,
    input  wire tts_pkg::tts_status_t status,
    output tts_pkg::tts_cmd_t         cmd,
    output logic                      busy,
    output logic                      result_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FREAD,
        S_FCMP,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   valid_reg;
    logic   valid_next;
    logic   accept;

    // A request is taken whenever the search engine is free.
    assign accept = start && !busy_reg;

    // Commands to the datapath.
    always_comb
    begin
        cmd.load   = accept && (mode == tts_pkg::MODE_LOAD);
        cmd.init   = accept && (mode == tts_pkg::MODE_CONVERT);
        cmd.eval   = (state_reg == S_EVAL);
        cmd.finish = (state_reg == S_FCMP);
    end

    // Next state: a read and an evaluation state per search pass, then read, compare, report.
    always_comb
    begin
        case (state_reg)
            S_IDLE, S_OUT:
            begin
                state_next = cmd.init ? S_READ : S_IDLE;
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = status.stop ? S_FREAD : S_READ;
            end
            S_FREAD:
            begin
                state_next = S_FCMP;
            end
            S_FCMP:
            begin
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next  = (state_next inside {S_READ, S_EVAL, S_FREAD, S_FCMP});
        valid_next = (state_next == S_OUT);
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = valid_reg;

    // The result strobe lasts one cycle.
    `TTS_ASSERT(a_strobe_single, clk, rst_n, result_valid |=> !result_valid)
    // No result is shown while a search is running.
    `TTS_NEVER(a_no_result_while_busy, clk, rst_n, busy && result_valid)
    // A result always follows the final compare.
    `TTS_ASSERT(a_result_after_cmp, clk, rst_n, result_valid |-> $past(state_reg == S_FCMP))

endmodule

`default_nettype wire

>>> tb/thermistor_table_search_core_tb.sv
`timescale 1ns / 1ps

module thermistor_table_search_core_tb;

    import tts_pkg::*;

    // The longest conversion runs MAX_STEPS+1 search passes; leave a small margin on top.
    localparam int SETTLE_CYCLES  = 2 * (TTS_MAX_STEPS + 1) + 3 + 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SEGMENTS       = 12;
    localparam int CONVERTS_PER_SEGMENT = 80;

    // Scoreboard: keeps a copy of the table and the size register, computes the
    // nearest-entry answer for each accepted conversion and checks results in order.
    class nearest_entry_tracker;
        logic [TTS_CFG_W-1:0]  size_reg = TTS_SIZE_RESET;
        logic [TTS_VOLT_W-1:0] volt_mem [TTS_TABLE_DEPTH];
        logic [TTS_TEMP_W-1:0] temp_mem [TTS_TABLE_DEPTH];
        tts_result_t           pending_answers [$];
        int unsigned           errors = 0;
        int unsigned           loads_seen = 0;
        int unsigned           conversions_seen = 0;
        int unsigned           results_checked = 0;

        function void set_table_size(logic [TTS_CFG_W-1:0] value);
            size_reg = value;
        endfunction

        // Size actually searched: the register clamped to at least two and at most the table depth.
        function int unsigned active_size();
            int unsigned s;
            s = size_reg;
            if (s < 2) s = 2;
            if (s > TTS_TABLE_DEPTH) s = TTS_TABLE_DEPTH;
            return s;
        endfunction

        function int unsigned entry_mv(int unsigned k);
            if (k >= TTS_TABLE_DEPTH) return 0;
            return volt_mem[k] * 10;
        endfunction

        // Entries at or past the active size count as infinitely high.
        function bit entry_above(int unsigned k, int unsigned size, int unsigned smp);
            if (k >= size || k >= TTS_TABLE_DEPTH) return 1'b1;
            return entry_mv(k) > smp;
        endfunction

        function tts_result_t nearest_entry(logic [TTS_MV_W-1:0] sample);
            int unsigned size, smp, pos, stp, iter, passes;
            int unsigned lo_mv, hi_mv, d_lo, d_hi, pick;
            tts_result_t ans;
            size   = active_size();
            smp    = sample;
            iter   = 1;
            stp    = size >> 1;
            pos    = stp;
            passes = 0;
            // Binary search for the bracketing pair, capped at MAX_STEPS passes.
            while (!(entry_mv(pos) <= smp && entry_above(pos + 1, size, smp))) begin
                if (passes >= TTS_MAX_STEPS) break;
                passes++;
                iter++;
                if (stp >= 2) stp = (iter < 31) ? (size >> iter) : 0;
                if (stp < 1) stp = 1;
                if (pos + stp > size - 1 || pos < stp) break;
                if (entry_mv(pos) < smp) pos += stp;
                else if (entry_mv(pos) > smp) pos -= stp;
            end
            if (pos == size - 1) pos -= 1;
            // Pick the nearer of the pair; a tie stays on the lower entry.
            lo_mv = entry_mv(pos);
            hi_mv = entry_mv(pos + 1);
            d_lo  = (lo_mv > smp) ? lo_mv - smp : smp - lo_mv;
            d_hi  = (hi_mv > smp) ? hi_mv - smp : smp - hi_mv;
            pick  = (d_hi < d_lo) ? pos + 1 : pos;
            if (pick >= TTS_TABLE_DEPTH) pick = TTS_TABLE_DEPTH - 1;
            ans.temperature  = temp_mem[pick];
            ans.chosen_index = pick[TTS_INDEX_W-1:0];
            return ans;
        endfunction

        function void note_request(tts_request_t req);
            if (req.mode == MODE_LOAD) begin
                loads_seen++;
                if (req.entry_index < TTS_TABLE_DEPTH) begin
                    volt_mem[req.entry_index] = req.entry_voltage;
                    temp_mem[req.entry_index] = req.entry_temperature;
                end
            end else begin
                conversions_seen++;
                pending_answers.push_back(nearest_entry(req.sample_mv));
            end
        endfunction

        function void check_result(tts_result_t got);
            tts_result_t want;
            results_checked++;
            if (pending_answers.size() == 0) begin
                $error("unexpected result: temperature %0d chosen_index %0d",
                       got.temperature, got.chosen_index);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.temperature !== want.temperature) begin
                $error("temperature: expected %0d, actual %0d",
                       want.temperature, got.temperature);
                errors++;
            end
            if (got.chosen_index !== want.chosen_index) begin
                $error("chosen_index: expected %0d, actual %0d",
                       want.chosen_index, got.chosen_index);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_answers.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    tts_request_t         request = '0;
    logic                 result_valid;
    tts_result_t          result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TTS_CFG_W-1:0] cfg_data = '0;

    nearest_entry_tracker sb = new;
    int unsigned          stall_cycles = 0;
    int unsigned          send_idle_pct = 13;
    int unsigned          seg_sizes [SEGMENTS] = '{32, 2, 0, 17, 1, 63, 8, 33, 3, 31, 16, 32};
    int unsigned          directed_mv [12] =
        '{0, 16383, 10230, 10229, 10231, 165, 166, 164, 5280, 5281, 9900, 330};

    thermistor_table_search_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Observe the edge: results first, then size writes, then new requests.
    always @(posedge clk) begin
        logic moved;
        moved = 1'b0;
        if (rst_n) begin
            if (result_valid) begin
                sb.check_result(result);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                sb.set_table_size(cfg_data);
                moved = 1'b1;
            end
            if (start && !busy) begin
                sb.note_request(request);
                moved = 1'b1;
            end
        end
        stall_cycles <= moved ? 0 : stall_cycles + 1;
    end

    // Watchdog on cycles without any progress.
    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Random sender idle cycles at the current rate.
    task automatic sender_gap();
        while ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Present one request and hold it until the block takes it.
    task automatic send_request(tts_request_t req);
        sender_gap();
        start   <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy);
    endtask

    // A request with every field random; callers then set the fields that matter.
    function automatic tts_request_t random_request();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return bits[$bits(tts_request_t)-1:0];
    endfunction

    task automatic load_entry(int unsigned k, int unsigned v, int unsigned t);
        tts_request_t req;
        req                   = random_request();
        req.mode              = MODE_LOAD;
        req.entry_index       = k[TTS_INDEX_W-1:0];
        req.entry_voltage     = v[TTS_VOLT_W-1:0];
        req.entry_temperature = t[TTS_TEMP_W-1:0];
        send_request(req);
    endtask

    task automatic convert_sample(int unsigned mv);
        tts_request_t req;
        req           = random_request();
        req.mode      = MODE_CONVERT;
        req.sample_mv = mv[TTS_MV_W-1:0];
        send_request(req);
    endtask

    // Wait until every conversion has reported and the block has settled.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_table_size(int unsigned value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value[TTS_CFG_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Fill all entries. Most tables ascend; some have duplicate runs, one flat
    // value, or pure noise so the step cap and odd orderings get exercised.
    task automatic load_table(int unsigned kind);
        int unsigned v, inc_lo, inc_hi;
        inc_lo = 1;
        inc_hi = $urandom_range(1, 33);
        if (kind == 7) begin
            inc_lo = 0;
            inc_hi = $urandom_range(1, 4);
        end
        v = $urandom_range(0, 1023 - 31 * inc_hi);
        if (kind == 8) v = $urandom_range(0, 1023);
        for (int unsigned k = 0; k < TTS_TABLE_DEPTH; k++) begin
            if (kind == 9) v = $urandom_range(0, 1023);
            load_entry(k, v, $urandom_range(0, 255));
            if (kind <= 7) v += $urandom_range(inc_lo, inc_hi);
        end
    endtask

    // Samples aimed at entries, midpoints (ties), near misses and the extremes.
    function automatic int unsigned pick_sample();
        int unsigned size, k, lo_mv, hi_mv, top_mv;
        size   = sb.active_size();
        k      = $urandom_range(0, size - 1);
        lo_mv  = sb.volt_mem[k] * 10;
        hi_mv  = (k + 1 < size) ? sb.volt_mem[k + 1] * 10 : lo_mv;
        top_mv = sb.volt_mem[size - 1] * 10;
        case ($urandom_range(0, 9))
            0: return lo_mv;
            1: return (lo_mv + hi_mv) / 2;
            2: return lo_mv + $urandom_range(1, 6);
            3: return (lo_mv > 6) ? lo_mv - $urandom_range(1, 6) : 0;
            4: return $urandom_range(0, 3);
            5: return 16383 - $urandom_range(0, 3);
            6: return top_mv + $urandom_range(0, 40);
            default: return $urandom_range(0, 16383);
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: evenly spaced table from 0 to full scale, at the reset size.
        for (int unsigned k = 0; k < TTS_TABLE_DEPTH; k++) begin
            load_entry(k, (k == 31) ? 1023 : k * 33, (k == 31) ? 255 : k * 8);
        end
        foreach (directed_mv[i]) convert_sample(directed_mv[i]);

        // Random segments, each with its own size setting and table.
        for (int s = 0; s < SEGMENTS; s++) begin
            send_idle_pct = (s < 4) ? 13 : (s < 8) ? 80 : 0;
            write_table_size(seg_sizes[s]);
            load_table($urandom_range(0, 9));
            for (int i = 0; i < CONVERTS_PER_SEGMENT; i++) begin
                if ($urandom_range(0, 99) < 5)
                    load_entry($urandom_range(0, 31), $urandom_range(0, 1023),
                               $urandom_range(0, 255));
                else
                    convert_sample(pick_sample());
            end
        end
        drain();

        $display("Run covered %0d table writes and %0d conversions over %0d size settings.",
                 sb.loads_seen, sb.conversions_seen, SEGMENTS + 1);
        $display("Checked %0d results, %0d mismatches.", sb.results_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
